[rtl/shuffled_minimal_standard_rng_assert.svh]
// Assertion macros for the controller of the shuffled minimal-standard generator RTL
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_ASSERT_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_ASSERT_SVH

// Same-cycle implication, idle during reset
`define SMSR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("smsr assertion failed");

// Next-cycle implication, idle during reset
`define SMSR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("smsr assertion failed");

`endif

[rtl/smsr_pkg.sv]
// Shared constants, command struct and modular reduction for the shuffled generator
`timescale 1ns / 1ps

package smsr_pkg;

    localparam int TABLE_SIZE   = 32;
    localparam int WARMUP_STEPS = 8;
    localparam int INIT_STEPS   = TABLE_SIZE + WARMUP_STEPS;
    localparam int CNT_W        = $clog2(INIT_STEPS);
    localparam int ADDR_W       = $clog2(TABLE_SIZE);
    localparam int VAL_W        = 31;
    localparam int MULT_W       = 15;
    localparam int PROD_W       = VAL_W + MULT_W;

    localparam logic [MULT_W-1:0] LCG_MULT     = MULT_W'(16807);
    localparam logic [VAL_W-1:0]  LCG_MOD      = VAL_W'(2147483647);
    localparam logic [VAL_W-1:0]  FRACTION_MAX = VAL_W'(2147483389);

    // Slot divisor is a power of two for the table size in use, so the slot is a shift
    localparam longint SLOT_DIV   = 64'd1 + (64'd2147483646 / TABLE_SIZE);
    localparam int     SLOT_SHIFT = $clog2(SLOT_DIV);

    typedef struct packed {
        logic              load_seed;
        logic              use_input;
        logic              mul;
        logic              rd_slot;
        logic              step_seed;
        logic              wr_table;
        logic [ADDR_W-1:0] wr_addr;
        logic              set_last;
        logic              draw_wr;
        logic              out_load;
        logic              out_from_ram;
    } t_dp_cmd;

    // Fold a product modulo 2^31 - 1: add high and low halves, subtract once
    function automatic logic [VAL_W-1:0] mersenne_reduce(input logic [PROD_W-1:0] p);
        logic [VAL_W:0] sum;
        sum = {1'b0, p[VAL_W-1:0]} + (VAL_W + 1)'(p[PROD_W-1:VAL_W]);
        if (sum >= {1'b0, LCG_MOD}) begin
            sum = sum - {1'b0, LCG_MOD};
        end
        return sum[VAL_W-1:0];
    endfunction

endpackage

[rtl/shuffled_minimal_standard_rng.sv]
// Top level of the shuffled minimal-standard random number generator
//
// Input stream: s_axis_tuser[0] selects the operation (0 draws the next number,
// 1 reseeds from s_axis_tdata[30:0] and then draws). A seed of zero, or equal to
// 2^31 - 1, starts the generator from one.
// Output stream: one transfer per input transfer, m_axis_tdata holds the raw
// shuffled value and its clamped fraction of 2^31 - 1.
// Handshake: a plain draw passes the accepting S_IDLE cycle, which registers the
// Lehmer multiply and issues the table read, and S_DRAW_B, which reduces the product,
// writes it back to the table and loads the output register. The next input can be
// taken in the cycle that output valid rises, and not while a draw is in progress;
// if the output stalls, the draw waits in S_HOLD until the output register frees.
// A reseed, and the first draw after reset, walks 40 generator steps, each through
// S_MUL and S_RED (8 warm-up steps, then 32 table fills), and then draws.
// Reset clears the controller only; the table holds nothing valid until the first
// initialisation, which the first item always performs.
// A result waits in the output register while m_axis_tready is low; the next
// input is still taken, and its result waits inside until the register frees.
`timescale 1ns / 1ps

module shuffled_minimal_standard_rng (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [30:0] seed_value, [31] zero
    input  logic [0:0]  s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // [30:0] raw_value, [61:31] uniform_fraction, [63:62] zero
);

    import smsr_pkg::*;

    t_dp_cmd          cmd;
    logic [VAL_W-1:0] raw_value;
    logic [VAL_W-1:0] uniform_fraction;

    smsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_func   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    smsr_datapath u_datapath (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .i_seed_value       (s_axis_tdata[VAL_W-1:0]),
        .o_raw_value        (raw_value),
        .o_uniform_fraction (uniform_fraction)
    );

    assign m_axis_tdata = {2'b00, uniform_fraction, raw_value};

endmodule

[rtl/smsr_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module smsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/smsr_datapath.sv]
// Datapath: Lehmer multiply and reduce, shuffle table, last output and result register
`timescale 1ns / 1ps

module smsr_datapath (
    input  logic                          i_clk,
    input  smsr_pkg::t_dp_cmd             i_cmd,
    input  logic [smsr_pkg::VAL_W-1:0]    i_seed_value,
    output logic [smsr_pkg::VAL_W-1:0]    o_raw_value,
    output logic [smsr_pkg::VAL_W-1:0]    o_uniform_fraction
);

    import smsr_pkg::*;

    logic [VAL_W-1:0]  r_seed;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_last;
    logic [ADDR_W-1:0] r_slot;
    logic [VAL_W-1:0]  r_out_raw;
    logic [VAL_W-1:0]  r_out_frac;

    logic [VAL_W-1:0]  n_seed;
    logic [VAL_W-1:0]  start_seed;
    logic [VAL_W-1:0]  ram_rdata;
    logic [ADDR_W-1:0] slot_now;
    logic [VAL_W-1:0]  out_src;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;

    // Zero and the modulus itself both reduce to a zero seed, which maps to one
    always_comb begin
        if ((i_seed_value == '0) || (i_seed_value == LCG_MOD)) begin
            start_seed = VAL_W'(1);
        end else begin
            start_seed = i_seed_value;
        end
    end

    assign n_seed    = mersenne_reduce(r_prod);
    assign slot_now  = ADDR_W'(r_last >> SLOT_SHIFT);
    assign ram_we    = i_cmd.wr_table | i_cmd.draw_wr;
    assign ram_waddr = i_cmd.wr_table ? i_cmd.wr_addr : r_slot;
    assign out_src   = i_cmd.out_from_ram ? ram_rdata : r_last;

    smsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (n_seed),
        .i_re    (i_cmd.rd_slot),
        .i_raddr (slot_now),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_seed <= i_cmd.use_input ? start_seed : VAL_W'(1);
        end else if (i_cmd.step_seed) begin
            r_seed <= n_seed;
        end
        if (i_cmd.mul) begin
            r_prod <= r_seed * LCG_MULT;
        end
        if (i_cmd.rd_slot) begin
            r_slot <= slot_now;
        end
        // Entry 0 of the fill becomes the first last output
        if (i_cmd.set_last) begin
            r_last <= n_seed;
        end else if (i_cmd.draw_wr) begin
            r_last <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_raw  <= out_src;
            r_out_frac <= (out_src > FRACTION_MAX) ? FRACTION_MAX : out_src;
        end
    end

    assign o_raw_value        = r_out_raw;
    assign o_uniform_fraction = r_out_frac;

endmodule

[rtl/smsr_ctrl.sv]
// Controller: sequences reseed warm-up, table fill and draws, owns the handshakes
`timescale 1ns / 1ps
`include "shuffled_minimal_standard_rng_assert.svh"

module smsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_func,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output smsr_pkg::t_dp_cmd o_cmd
);

    import smsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_DRAW_A,
        S_DRAW_B,
        S_HOLD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_loaded, n_loaded;
    logic             r_out_valid, n_out_valid;

    logic accept;
    logic need_init;
    logic can_load;

    assign accept    = (r_state == S_IDLE) && i_in_valid;
    assign need_init = i_in_func || !r_loaded;
    assign can_load  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_loaded    = r_loaded;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        // Drop the valid flag once the receiver takes the transfer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (need_init) begin
                        o_cmd.load_seed = 1'b1;
                        o_cmd.use_input = i_in_func;
                        n_cnt           = CNT_W'(INIT_STEPS - 1);
                        n_loaded        = 1'b1;
                        n_state         = S_MUL;
                    end else begin
                        o_cmd.mul     = 1'b1;
                        o_cmd.rd_slot = 1'b1;
                        n_state       = S_DRAW_B;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                // Warm-up steps leave the table alone; the fill runs from the top entry down
                o_cmd.step_seed = 1'b1;
                o_cmd.wr_table  = (r_cnt < CNT_W'(TABLE_SIZE));
                o_cmd.wr_addr   = r_cnt[ADDR_W-1:0];
                o_cmd.set_last  = (r_cnt == '0);
                if (r_cnt == '0) begin
                    n_state = S_DRAW_A;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_MUL;
                end
            end
            S_DRAW_A: begin
                o_cmd.mul     = 1'b1;
                o_cmd.rd_slot = 1'b1;
                n_state       = S_DRAW_B;
            end
            S_DRAW_B: begin
                o_cmd.step_seed = 1'b1;
                o_cmd.draw_wr   = 1'b1;
                if (can_load) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_ram = 1'b1;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                // Hold the result in the last-output register until the slot frees
                if (can_load) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `SMSR_ASSERT_IMPLY(a_cnt_zero_idle, i_clk, i_rst_n, r_state == S_IDLE, r_cnt == '0)
    `SMSR_ASSERT_NEXT(a_draw_two_cycles, i_clk, i_rst_n, accept && !need_init, r_state == S_DRAW_B)
    `SMSR_ASSERT_NEXT(a_loaded_sticks, i_clk, i_rst_n, r_loaded, r_loaded)
    `SMSR_ASSERT_IMPLY(a_hold_needs_stall, i_clk, i_rst_n, r_state == S_HOLD, r_out_valid)
    `SMSR_ASSERT_IMPLY(a_fill_in_red, i_clk, i_rst_n, o_cmd.wr_table, r_state == S_RED && r_loaded)

endmodule

[sim/tb_shuffled_minimal_standard_rng.sv]
// Self-checking testbench for the shuffled minimal-standard random number generator
`timescale 1ns / 1ps

module tb_shuffled_minimal_standard_rng;

    import smsr_pkg::TABLE_SIZE;

    localparam logic        OP_DRAW    = 1'b0;
    localparam logic        OP_RESEED  = 1'b1;
    localparam int          INIT_WALK  = TABLE_SIZE + 8;
    localparam longint      LEHMER_A   = 64'd16807;
    localparam longint      LEHMER_M   = 64'd2147483647;
    localparam longint      SLOT_STEP  = 64'd1 + (64'd2147483646 / TABLE_SIZE);
    localparam logic [30:0] FRAC_CAP   = 31'd2147483389;
    localparam logic [30:0] SEED_MAX   = 31'd2147483646;
    localparam logic [30:0] SEED_MOD   = 31'h7FFF_FFFF;
    localparam int          LONG_HOLD  = 400;
    localparam int          IDLE_LIMIT = 3000;
    localparam int          TAIL_WAIT  = 100;
    localparam int          N_RANDOM   = 600;

    typedef struct packed {
        logic [30:0] raw;
        logic [30:0] frac;
    } t_rng_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // [30:0] seed_value, [31] zero
    logic [0:0]  s_axis_tuser = '0;  // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // [30:0] raw_value, [61:31] uniform_fraction, [63:62] zero

    shuffled_minimal_standard_rng dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Generator state as the block should hold it
    logic [30:0] gen_seed = 31'd1;
    logic [30:0] shuf_table [TABLE_SIZE];
    logic [30:0] prev_out = 31'd0;
    bit          table_ready = 1'b0;

    t_rng_out    draw_q [$];
    int          mismatches = 0;
    int          idle_cycles = 0;

    bit          rx_free = 1'b0;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold_seen = 1'b0;
    int          rx_wait = 0;
    bit          tx_free = 1'b0;

    function automatic logic [30:0] lehmer_advance(input logic [30:0] x);
        longint unsigned p;
        p = longint'(x) * LEHMER_A;
        return 31'(p % LEHMER_M);
    endfunction

    function automatic void load_table(input logic [30:0] start);
        logic [30:0] s;
        int          n;
        // Reduce the modulus itself to zero, then map zero to one
        s = (start == SEED_MOD) ? 31'd0 : start;
        if (s == 31'd0) begin
            s = 31'd1;
        end
        for (n = INIT_WALK; n > 0; n--) begin
            s = lehmer_advance(s);
            if (n - 1 < TABLE_SIZE) begin
                shuf_table[n-1] = s;
            end
        end
        gen_seed    = s;
        prev_out    = shuf_table[0];
        table_ready = 1'b1;
    endfunction

    function automatic t_rng_out next_draw(input logic func, input logic [30:0] seed);
        t_rng_out    r;
        longint      slot;
        logic [30:0] v;
        if (func == OP_RESEED) begin
            load_table(seed);
        end else if (!table_ready) begin
            load_table(31'd1);
        end
        gen_seed = lehmer_advance(gen_seed);
        slot = longint'(prev_out) / SLOT_STEP;
        if (slot >= TABLE_SIZE) begin
            slot = TABLE_SIZE - 1;
        end
        v = shuf_table[slot];
        prev_out = v;
        shuf_table[slot] = gen_seed;
        r.raw  = v;
        r.frac = (v > FRAC_CAP) ? FRAC_CAP : v;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [30:0] want,
                                 input logic [30:0] got);
        if (mismatches < 10) begin
            $display("%0t: %s expected %0d got %0d", $realtime, field, want, got);
        end
        mismatches++;
    endtask

    // Check each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_rng_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (draw_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
                end
                mismatches++;
            end else begin
                want = draw_q.pop_front();
                if (m_axis_tdata[30:0] !== want.raw) begin
                    note_mismatch("raw_value", want.raw, m_axis_tdata[30:0]);
                end
                if (m_axis_tdata[61:31] !== want.frac) begin
                    note_mismatch("uniform_fraction", want.frac, m_axis_tdata[61:31]);
                end
                if (m_axis_tdata[63:62] !== 2'b00) begin
                    note_mismatch("padding", 31'd0, 31'(m_axis_tdata[63:62]));
                end
            end
        end
    end

    // Receiver: random stalls, a long hold on request, or always ready
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_req;
            rx_wait       <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_free || $urandom_range(0, 99) < 75) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_wait <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 3);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("shuffled_minimal_standard_rng: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic func, input logic [30:0] seed);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, seed};
        do @(posedge i_clk); while (!s_axis_tready);
        draw_q.push_back(next_draw(func, seed));
    endtask

    task automatic sender_gap();
        int n;
        if (tx_free) begin
            return;
        end
        n = $urandom_range(0, 99);
        if (n < 65) begin
            n = 0;
        end else if (n < 95) begin
            n = $urandom_range(1, 4);
        end else begin
            n = $urandom_range(15, 60);
        end
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (draw_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [30:0] any_seed();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return 31'd0;
        end else if (pick == 1) begin
            return SEED_MOD;
        end else if (pick == 2) begin
            return SEED_MAX;
        end
        return 31'($urandom);
    endfunction

    task automatic test_draw_before_seed();
        // First item after reset is a draw, so the block seeds itself from one
        send_item(OP_DRAW, 31'd0);
        sender_gap();
        send_item(OP_DRAW, SEED_MOD);
        sender_gap();
        send_item(OP_DRAW, 31'h2AAA_AAAA);
    endtask

    task automatic test_seed_extremes();
        logic [30:0] seeds [8];
        int          i;
        seeds = '{31'd0, SEED_MOD, 31'd1, SEED_MAX, 31'h2AAA_AAAA, 31'h5555_5555,
                  31'd16807, 31'($urandom)};
        for (i = 0; i < 8; i++) begin
            sender_gap();
            send_item(OP_RESEED, seeds[i]);
            sender_gap();
            send_item(OP_DRAW, 31'($urandom));
        end
    endtask

    task automatic test_output_backpressure();
        int i;
        // Hold the receiver off while offering draws, with one reseed among them, so the block fills and stalls
        rx_hold_req <= ~rx_hold_req;
        tx_free = 1'b1;
        for (i = 0; i < 20; i++) begin
            send_item((i == 7) ? OP_RESEED : OP_DRAW, 31'($urandom));
        end
        tx_free = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_drained();
        repeat ($urandom_range(1, 10)) @(posedge i_clk);
        send_item(OP_DRAW, 31'($urandom));
        wait_drained();
        send_item(OP_RESEED, any_seed());
        send_item(OP_DRAW, 31'($urandom));
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < N_RANDOM; i++) begin
            // Every third stretch of a hundred runs with no idling at all
            if (i % 100 == 0) begin
                tx_free  = ((i / 100) % 3 == 2);
                rx_free <= ((i / 100) % 3 == 2);
            end
            sender_gap();
            if ($urandom_range(0, 99) < 8) begin
                send_item(OP_RESEED, any_seed());
            end else begin
                send_item(OP_DRAW, 31'($urandom));
            end
        end
        tx_free  = 1'b0;
        rx_free <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_draw_before_seed();
        test_seed_extremes();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix();
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        mismatches += draw_q.size();
        if (mismatches == 0) begin
            $display("shuffled_minimal_standard_rng: match");
        end else begin
            $display("shuffled_minimal_standard_rng: mismatch");
        end
        $finish;
    end

endmodule
